>>> hdl/mlfq_pkg.sv
package mlfq_pkg;

  localparam int LEVELS = 3;
  localparam int LVL_W  = 2;
  localparam int DW     = 16;
  localparam int TW     = 32;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] REG_Q0 = 2'd0;
  localparam logic [1:0] REG_Q1 = 2'd1;
  localparam logic [1:0] REG_Q2 = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic tick;
    logic scan_start;
    logic scan_chk;
    logic pop;
    logic latch;
    logic look;
    logic run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic any_ready;
    logic slice_active;
    logic last_unit;
    logic rem_zero;
  } stat_t;

endpackage

>>> hdl/mlfq_tick_scheduler.sv
// Load, clear and ignored modes leave the FSM idle; busy stays low. A tick mid-slice
// goes idle, run, report. A slice start adds an arrival scan over the N loaded
// entries, then select, pop and look (repeated per zero-burst entry popped) before
// run; a slice end adds a scan and finish after run. The result strobes in the tick's
// last cycle. One tick is in flight at a time; the receiver cannot stall the result.
// Synchronous reset clears queues, counts and time and sets the quanta to 4, 8 and 16.
module mlfq_tick_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] proc_id,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  output logic        result_valid,
  output logic [15:0] running_pid,
  output logic        idle,
  output logic        all_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mlfq_pkg::LEVELS-1:0][mlfq_pkg::DW-1:0] quantum;
  mlfq_pkg::cmd_t  cmd;
  mlfq_pkg::stat_t stat;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum[0] <= 16'd4;
      quantum[1] <= 16'd8;
      quantum[2] <= 16'd16;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        mlfq_pkg::REG_Q0: quantum[0] <= pwdata[15:0];
        mlfq_pkg::REG_Q1: quantum[1] <= pwdata[15:0];
        mlfq_pkg::REG_Q2: quantum[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mlfq_pkg::REG_Q0: prdata = {16'b0, quantum[0]};
      mlfq_pkg::REG_Q1: prdata = {16'b0, quantum[1]};
      mlfq_pkg::REG_Q2: prdata = {16'b0, quantum[2]};
      default:          prdata = '0;
    endcase
  end

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .stat(stat),
    .cmd(cmd), .busy(busy), .result_valid(result_valid)
  );

  mlfq_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .quantum(quantum),
    .proc_id(proc_id), .arrival(arrival), .burst(burst),
    .running_pid(running_pid), .idle(idle), .all_done(all_done)
  );

endmodule

>>> hdl/mlfq_ram.sv
module mlfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mlfq_ctrl.sv
module mlfq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode,
  input  mlfq_pkg::stat_t stat,
  output mlfq_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            result_valid
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADM_RD  = 4'd1;
  localparam logic [3:0] S_ADM_CHK = 4'd2;
  localparam logic [3:0] S_SEL     = 4'd3;
  localparam logic [3:0] S_POP     = 4'd4;
  localparam logic [3:0] S_LOOK    = 4'd5;
  localparam logic [3:0] S_RUN     = 4'd6;
  localparam logic [3:0] S_FINISH  = 4'd7;
  localparam logic [3:0] S_REPORT  = 4'd8;

  logic [3:0] state, state_next;
  logic       phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            mlfq_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            mlfq_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            mlfq_pkg::MODE_TICK: begin
              cmd.tick = 1'b1;
              if (stat.slice_active) begin
                state_next = S_RUN;
              end else begin
                cmd.scan_start = 1'b1;
                phase_next     = 1'b0;
                state_next     = S_ADM_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADM_RD: begin
        if (stat.scan_done) begin
          state_next = phase ? S_FINISH : S_SEL;
        end else begin
          state_next = S_ADM_CHK;
        end
      end
      S_ADM_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = S_ADM_RD;
      end
      S_SEL: begin
        if (stat.any_ready) begin
          cmd.pop    = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_RUN;
        end
      end
      S_POP: begin
        cmd.latch  = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        // zero-burst entry finishes at once; pick again
        state_next = stat.rem_zero ? S_SEL : S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (stat.slice_active && stat.last_unit) begin
          cmd.scan_start = 1'b1;
          phase_next     = 1'b1;
          state_next     = S_ADM_RD;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_REPORT);

endmodule

>>> hdl/mlfq_dpath.sv
module mlfq_dpath #(
  parameter int MAX_PROCS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mlfq_pkg::cmd_t                         cmd,
  output mlfq_pkg::stat_t                        stat,
  input  logic [mlfq_pkg::LEVELS-1:0][mlfq_pkg::DW-1:0] quantum,
  input  logic [mlfq_pkg::DW-1:0]                proc_id,
  input  logic [mlfq_pkg::DW-1:0]                arrival,
  input  logic [mlfq_pkg::DW-1:0]                burst,
  output logic [mlfq_pkg::DW-1:0]                running_pid,
  output logic                                   idle,
  output logic                                   all_done
);

  localparam int IW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW     = $clog2(MAX_PROCS + 1);
  localparam int SLOT_D = (2 ** IW) * 4;
  localparam int DW     = mlfq_pkg::DW;
  localparam int LW     = mlfq_pkg::LVL_W;

  logic [CW-1:0]        loaded_total, finished_total, scan_i;
  logic [MAX_PROCS-1:0] admitted_mark;
  logic [IW-1:0]        level_head [mlfq_pkg::LEVELS];
  logic [IW-1:0]        level_tail [mlfq_pkg::LEVELS];
  logic [CW-1:0]        level_fill [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::TW-1:0] now_time;
  logic [IW-1:0]        slice_owner;
  logic [LW-1:0]        slice_level, sel_lvl, first_lvl, push_lvl, next_lvl;
  logic [DW-1:0]        slice_left, cur_pid, cur_rem, run_pid;
  logic                 slice_active, ticking_started, run_idle;

  logic [DW-1:0] arr_rdata, pid_rdata, rem_rdata, q_sel, q_eff, slice_len;
  logic [IW-1:0] slot_rdata, push_idx, scan_idx, load_idx, rem_waddr;
  logic [DW-1:0] rem_wdata;
  logic          load_ok, adm_hit, push_en, rem_we, demote;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign scan_idx = scan_i[IW-1:0];
  assign load_idx = loaded_total[IW-1:0];
  assign load_ok  = cmd.load && !ticking_started && (loaded_total < CW'(MAX_PROCS));
  assign adm_hit  = !admitted_mark[scan_idx] && ({16'b0, arr_rdata} <= now_time);
  assign demote   = cmd.finish && (cur_rem != '0);
  assign next_lvl = (slice_level == LW'(mlfq_pkg::LEVELS - 1)) ? slice_level
                                                                : slice_level + 1'b1;

  always_comb begin
    priority if (level_fill[0] != '0) first_lvl = 2'd0;
    else if (level_fill[1] != '0)     first_lvl = 2'd1;
    else                              first_lvl = 2'd2;
  end

  always_comb begin
    push_en  = 1'b0;
    push_lvl = 2'd0;
    push_idx = scan_idx;
    if (cmd.scan_chk && adm_hit) begin
      push_en = 1'b1;
    end else if (demote) begin
      push_en  = 1'b1;
      push_lvl = next_lvl;
      push_idx = slice_owner;
    end
  end

  always_comb begin
    unique case (sel_lvl)
      2'd0:    q_sel = quantum[0];
      2'd1:    q_sel = quantum[1];
      default: q_sel = quantum[2];
    endcase
    q_eff     = (q_sel == '0) ? 16'd1 : q_sel;
    slice_len = (rem_rdata < q_eff) ? rem_rdata : q_eff;
  end

  assign rem_we    = load_ok || demote;
  assign rem_waddr = load_ok ? load_idx : slice_owner;
  assign rem_wdata = load_ok ? burst : cur_rem;

  mlfq_ram #(.WIDTH(DW), .DEPTH(2 ** IW)) u_arr (
    .clk(clk), .we(load_ok), .waddr(load_idx), .wdata(arrival),
    .raddr(scan_idx), .rdata(arr_rdata)
  );

  mlfq_ram #(.WIDTH(DW), .DEPTH(2 ** IW)) u_pid (
    .clk(clk), .we(load_ok), .waddr(load_idx), .wdata(proc_id),
    .raddr(slot_rdata), .rdata(pid_rdata)
  );

  mlfq_ram #(.WIDTH(DW), .DEPTH(2 ** IW)) u_rem (
    .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .raddr(slot_rdata), .rdata(rem_rdata)
  );

  mlfq_ram #(.WIDTH(IW), .DEPTH(SLOT_D)) u_slot (
    .clk(clk), .we(push_en), .waddr({push_lvl, level_tail[push_lvl]}), .wdata(push_idx),
    .raddr({first_lvl, level_head[first_lvl]}), .rdata(slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      loaded_total    <= '0;
      finished_total  <= '0;
      scan_i          <= '0;
      admitted_mark   <= '0;
      now_time        <= '0;
      slice_owner     <= '0;
      slice_level     <= '0;
      slice_left      <= '0;
      slice_active    <= 1'b0;
      ticking_started <= 1'b0;
      sel_lvl         <= '0;
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        level_head[l] <= '0;
        level_tail[l] <= '0;
        level_fill[l] <= '0;
      end
    end else begin
      if (load_ok) begin
        admitted_mark[load_idx] <= 1'b0;
        loaded_total            <= loaded_total + 1'b1;
      end
      if (cmd.tick) begin
        ticking_started <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_i <= '0;
      end
      if (cmd.scan_chk) begin
        if (adm_hit) begin
          admitted_mark[scan_idx] <= 1'b1;
        end
        scan_i <= scan_i + 1'b1;
      end
      if (push_en) begin
        level_tail[push_lvl] <= ptr_inc(level_tail[push_lvl]);
        level_fill[push_lvl] <= level_fill[push_lvl] + 1'b1;
      end
      if (cmd.pop) begin
        sel_lvl               <= first_lvl;
        level_head[first_lvl] <= ptr_inc(level_head[first_lvl]);
        level_fill[first_lvl] <= level_fill[first_lvl] - 1'b1;
      end
      if (cmd.latch) begin
        slice_owner <= slot_rdata;
      end
      if (cmd.look) begin
        if (rem_rdata == '0) begin
          finished_total <= finished_total + 1'b1;
        end else begin
          slice_level  <= sel_lvl;
          slice_left   <= slice_len;
          slice_active <= 1'b1;
        end
      end
      if (cmd.run) begin
        if (now_time != '1) begin
          now_time <= now_time + 1'b1;
        end
        if (slice_active) begin
          slice_left <= slice_left - 1'b1;
          if (slice_left == 16'd1) begin
            slice_active <= 1'b0;
          end
        end
      end
      if (cmd.finish && !demote) begin
        finished_total <= finished_total + 1'b1;
      end
    end
  end

  // payload of the running slice and of the pending result
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      cur_pid <= pid_rdata;
      cur_rem <= rem_rdata;
    end
    if (cmd.run) begin
      if (slice_active) begin
        cur_rem  <= cur_rem - 1'b1;
        run_pid  <= cur_pid;
        run_idle <= 1'b0;
      end else begin
        run_pid  <= '0;
        run_idle <= 1'b1;
      end
    end
  end

  assign stat.scan_done    = (scan_i == loaded_total);
  assign stat.any_ready    = (level_fill[0] != '0) || (level_fill[1] != '0) ||
                             (level_fill[2] != '0);
  assign stat.slice_active = slice_active;
  assign stat.last_unit    = (slice_left == 16'd1);
  assign stat.rem_zero     = (rem_rdata == '0);

  assign running_pid = run_pid;
  assign idle        = run_idle;
  assign all_done    = (finished_total == loaded_total);

`ifndef SYNTHESIS
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (rst)
    finished_total <= loaded_total)
    else $error("finished count exceeds loaded count");

  a_fill_le_loaded: assert property (@(posedge clk) disable iff (rst)
    ({2'b0, level_fill[0]} + {2'b0, level_fill[1]} + {2'b0, level_fill[2]})
      <= {2'b0, loaded_total})
    else $error("queued entries exceed loaded count");

  a_active_left: assert property (@(posedge clk) disable iff (rst)
    slice_active |-> (slice_left != '0) && (slice_left <= cur_rem))
    else $error("active slice without time left");

  a_no_load_after_tick: assert property (@(posedge clk) disable iff (rst)
    (ticking_started && !cmd.clear) |=> $stable(loaded_total))
    else $error("table grew after ticking started");
`endif

endmodule

>>> verif/tb.sv
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = mlfq_pkg::MODE_LOAD;
  logic [15:0] proc_id = '0;
  logic [15:0] arrival = '0;
  logic [15:0] burst = '0;
  logic        result_valid;
  logic [15:0] running_pid;
  logic        idle;
  logic        all_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam int NPROC = 16;
  localparam logic [1:0] MODE_NONE = 2'd3;

  mlfq_tick_scheduler #(.MAX_PROCS(NPROC)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [15:0] pid;
    logic        idl;
    logic        dn;
  } tick_report_t;

  class sched_scoreboard;
    logic [15:0] quantum [mlfq_pkg::LEVELS];
    logic [15:0] pid_tab [NPROC];
    logic [15:0] arr_tab [NPROC];
    logic [15:0] rem_tab [NPROC];
    bit          admitted [NPROC];
    int          slots [mlfq_pkg::LEVELS][NPROC];
    int          head [mlfq_pkg::LEVELS];
    int          tail [mlfq_pkg::LEVELS];
    int          fill [mlfq_pkg::LEVELS];
    int          loaded;
    int          finished;
    logic [31:0] now;
    int          owner;
    int          cur_lvl;
    int          left;
    bit          active;
    bit          started;
    tick_report_t pending_reports[$];
    int          errors;

    function void clear_all();
      for (int i = 0; i < NPROC; i++) admitted[i] = 0;
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        head[l] = 0; tail[l] = 0; fill[l] = 0;
      end
      loaded = 0; finished = 0; now = '0;
      owner = 0; cur_lvl = 0; left = 0; active = 0; started = 0;
    endfunction

    function void init();
      quantum[0] = 16'd4; quantum[1] = 16'd8; quantum[2] = 16'd16;
      errors = 0;
      clear_all();
    endfunction

    function void push(int l, int idx);
      if (fill[l] >= NPROC) return;
      slots[l][tail[l]] = idx;
      tail[l] = (tail[l] + 1) % NPROC;
      fill[l]++;
    endfunction

    function void admit();
      for (int i = 0; i < loaded; i++)
        if (!admitted[i] && {16'd0, arr_tab[i]} <= now) begin
          push(0, i);
          admitted[i] = 1;
        end
    endfunction

    function void begin_slice();
      int l, idx, qv;
      for (int g = 0; g <= NPROC; g++) begin
        admit();
        l = -1;
        for (int k = mlfq_pkg::LEVELS - 1; k >= 0; k--) if (fill[k] > 0) l = k;
        if (l < 0) return;
        idx = slots[l][head[l]];
        head[l] = (head[l] + 1) % NPROC;
        fill[l]--;
        if (rem_tab[idx] == 0) begin
          finished++;
          continue;
        end
        qv = (quantum[l] == 0) ? 1 : quantum[l];
        owner = idx; cur_lvl = l; active = 1;
        left = (rem_tab[idx] < qv) ? rem_tab[idx] : qv;
        return;
      end
    endfunction

    function void note_transfer(logic [1:0] m, logic [15:0] p, logic [15:0] a,
                                logic [15:0] b);
      tick_report_t r;
      if (m == mlfq_pkg::MODE_LOAD) begin
        if (!started && loaded < NPROC) begin
          pid_tab[loaded] = p; arr_tab[loaded] = a; rem_tab[loaded] = b;
          admitted[loaded] = 0;
          loaded++;
        end
        return;
      end
      if (m == mlfq_pkg::MODE_CLEAR) begin
        clear_all();
        return;
      end
      if (m != mlfq_pkg::MODE_TICK) return;
      started = 1;
      if (!active) begin_slice();
      r.pid = '0; r.idl = 1'b1;
      if (active) begin
        r.pid = pid_tab[owner]; r.idl = 1'b0;
        rem_tab[owner]--;
        left--;
        if (now != '1) now++;
        if (left == 0) begin
          active = 0;
          admit();
          if (rem_tab[owner] > 0)
            push((cur_lvl < mlfq_pkg::LEVELS - 1) ? cur_lvl + 1 : cur_lvl, owner);
          else finished++;
        end
      end else if (now != '1) now++;
      r.dn = (finished == loaded);
      pending_reports.push_back(r);
    endfunction

    function void check_result(logic [15:0] p, logic i, logic d);
      tick_report_t e;
      if (pending_reports.size() == 0) begin
        $error("unexpected result pid=%0h idle=%0b all_done=%0b", p, i, d);
        errors++;
        return;
      end
      e = pending_reports.pop_front();
      if (p !== e.pid) begin
        $error("running_pid expected %0h actual %0h", e.pid, p); errors++;
      end
      if (i !== e.idl) begin
        $error("idle expected %0b actual %0b", e.idl, i); errors++;
      end
      if (d !== e.dn) begin
        $error("all_done expected %0b actual %0b", e.dn, d); errors++;
      end
    endfunction
  endclass

  sched_scoreboard sb;
  int sent = 0;

  always @(posedge clk)
    if (!rst && result_valid) sb.check_result(running_pid, idle, all_done);

  task automatic maybe_gap();
    int n;
    if (sent < 1150 && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      @(negedge clk) start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic issue(logic [1:0] m, logic [15:0] p, logic [15:0] a, logic [15:0] b);
    maybe_gap();
    @(negedge clk);
    start <= 1'b1; mode <= m; proc_id <= p; arrival <= a; burst <= b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_transfer(m, p, a, b);
    sent++;
  endtask

  task automatic tick();
    issue(mlfq_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_quantum(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(0, 65535)), v};
    @(negedge clk) penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    sb.quantum[idx] = v;
    @(negedge clk) begin
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    end
  endtask

  function automatic logic [15:0] pick_quantum();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic run_workload();
    int n, t;
    n = $urandom_range(0, 18);
    for (int k = 0; k < n; k++)
      issue(mlfq_pkg::MODE_LOAD, 16'($urandom),
            ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30)),
            ($urandom_range(0, 9) == 0) ? 16'($urandom) :
            ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
    t = $urandom_range(1, 80);
    for (int k = 0; k < t; k++) begin
      case ($urandom_range(0, 39))
        0, 1: issue(MODE_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
        2:    issue(mlfq_pkg::MODE_LOAD, 16'($urandom), 16'($urandom_range(0, 20)),
                    16'($urandom_range(0, 9)));
        3:    issue(mlfq_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        default: tick();
      endcase
    end
    issue(mlfq_pkg::MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // defaults: full-range fields, zero burst, late arrival
    issue(mlfq_pkg::MODE_LOAD, 16'hFFFF, 16'd0, 16'd5);
    issue(mlfq_pkg::MODE_LOAD, 16'h0000, 16'd0, 16'd0);
    issue(mlfq_pkg::MODE_LOAD, 16'h5A5A, 16'd2, 16'd1);
    issue(mlfq_pkg::MODE_LOAD, 16'hA5A5, 16'hFFFF, 16'hFFFF);
    repeat (8) tick();
    issue(mlfq_pkg::MODE_LOAD, 16'h1111, 16'd0, 16'd1);
    issue(MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    tick();
    issue(mlfq_pkg::MODE_CLEAR, 16'h0, 16'h0, 16'h0);
    drain();

    write_quantum(mlfq_pkg::REG_Q0, 16'd1);
    write_quantum(mlfq_pkg::REG_Q1, 16'd0);
    write_quantum(mlfq_pkg::REG_Q2, 16'hFFFF);
    // overfill the table
    for (int k = 0; k < 17; k++)
      issue(mlfq_pkg::MODE_LOAD, 16'(k + 1), 16'd0, (k == 3) ? 16'd0 : 16'd2);
    tick();
    drain();

    while (sent < 1300) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_quantum(mlfq_pkg::REG_Q0, pick_quantum());
        write_quantum(mlfq_pkg::REG_Q1, pick_quantum());
        write_quantum(mlfq_pkg::REG_Q2, pick_quantum());
      end
      run_workload();
    end
    drain();

    if (sb.pending_reports.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
